// ===== src/fts_pkg.sv =====
// Package: types, constants and helpers shared by the fixed-timestep step scheduler.
package fts_pkg;

  localparam int ACC_W        = 40;
  localparam int TS_W         = 30;
  localparam int DELTA_W      = 32;
  localparam int STEPS_W      = 5;
  localparam int WORLDS_W     = 4;
  localparam int MASK_W       = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 30;
  localparam int S_TDATA_W    = 48;
  localparam int M_TDATA_W    = 16;

  localparam int MAX_WORLDS   = 8;
  localparam int MAX_STEP_CAP = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int CAP_LIMIT    = (MAX_STEP_CAP < RESULT_LIMIT) ? MAX_STEP_CAP : RESULT_LIMIT;

  localparam logic [ACC_W-1:0] TOLERANCE_NS = ACC_W'(1000);
  localparam logic signed [ACC_W-1:0] ACC_FLOOR = -(ACC_W'(1000));

  localparam logic [TS_W-1:0]     TIMESTEP_RST  = TS_W'(16666667);
  localparam logic [STEPS_W-1:0]  MAX_STEPS_RST = STEPS_W'(1);
  localparam logic [WORLDS_W-1:0] WORLDS_RST    = WORLDS_W'(0);
  localparam logic                DYN_EN_RST    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TIMESTEP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WORLDS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DYN_EN        = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_PREP,
    ST_ADD,
    ST_CHECK,
    ST_SUB,
    ST_EMIT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [TS_W-1:0]    timestep;
    logic [STEPS_W-1:0] cap;
    logic [MASK_W-1:0]  world_mask;
    logic               dyn_en;
  } cfg_t;

  function automatic logic [MASK_W-1:0] world_mask(input logic [WORLDS_W-1:0] n);
    logic [MASK_W-1:0] m;
    int nsat;
    nsat = (int'(n) > MAX_WORLDS) ? MAX_WORLDS : int'(n);
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (i < nsat);
    end
    return m;
  endfunction

  function automatic logic [STEPS_W-1:0] eff_cap(input logic [STEPS_W-1:0] ms);
    logic [STEPS_W-1:0] c;
    if (ms == '0) begin
      c = STEPS_W'(1);
    end else if (int'(ms) > CAP_LIMIT) begin
      c = STEPS_W'(CAP_LIMIT);
    end else begin
      c = ms;
    end
    return c;
  endfunction

endpackage

// ===== src/fixed_timestep_step_scheduler.sv =====
// Top level: fixed-timestep step scheduler with sequencer around a shared add/subtract unit.
// Sequence: an update that cannot step goes straight to the acknowledge state; otherwise the
// threshold is prepared, delta is added, and each check that finds a step due leads to a subtract
// of the timestep and a step result, with an acknowledge when no step is due at all.
// A new update is taken only in idle, after its last result or acknowledge; output stalls hold it.
// Reset: synchronous; state and configuration registers reset, accumulator cleared, output empty.
module fixed_timestep_step_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // step_pending[0], delta_ns[32:1], world_ready[33], pause_physics[34],
  // pause_dynamics[35], pause_collision[36], world_pause_mask[44:37], zero[47:45]
  input  logic [fts_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // dynamics_update[0], collision_update_mask[8:1], zero[15:9]
  output logic [fts_pkg::M_TDATA_W-1:0]   m_tdata,
  // step_valid[0]
  output logic                            m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fts_pkg::*;

  cfg_t cfg;

  state_t state, state_next;

  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   tsm;
  logic [DELTA_W-1:0] delta;
  logic [STEPS_W-1:0] steps;
  logic [STEPS_W-1:0] steps_inc;
  logic               last_flag;
  logic               dyn;
  logic [MASK_W-1:0]  col;

  logic               out_valid;
  logic               out_step;
  logic               out_dyn;
  logic [MASK_W-1:0]  out_col;
  logic               out_last;

  alu_op_t            alu_op;
  logic [ACC_W-1:0]   alu_a;
  logic [ACC_W-1:0]   alu_b;
  logic [ACC_W-1:0]   alu_y;
  logic               alu_neg;

  logic               in_fire;
  logic               out_free;
  logic               cannot_step;
  logic               at_cap;

  logic               in_pending;
  logic [DELTA_W-1:0] in_delta;
  logic               in_ready;
  logic               in_p_phys;
  logic               in_p_dyn;
  logic               in_p_col;
  logic [MASK_W-1:0]  in_wmask;

  fts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fts_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y),
    .neg (alu_neg)
  );

  assign in_pending = s_tdata[0];
  assign in_delta   = s_tdata[32:1];
  assign in_ready   = s_tdata[33];
  assign in_p_phys  = s_tdata[34];
  assign in_p_dyn   = s_tdata[35];
  assign in_p_col   = s_tdata[36];
  assign in_wmask   = s_tdata[44:37];

  assign s_tready    = (state == ST_IDLE);
  assign in_fire     = s_tvalid && s_tready;
  assign out_free    = !out_valid || m_tready;
  assign cannot_step = !in_pending || !in_ready || in_p_phys;
  assign steps_inc   = steps + STEPS_W'(1);
  assign at_cap      = (steps_inc == cfg.cap);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_op     = ALU_ADD;
    alu_a      = acc;
    alu_b      = tsm;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = cannot_step ? ST_ACK : ST_PREP;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_PREP: begin
        alu_op     = ALU_SUB;
        alu_a      = ACC_W'(cfg.timestep);
        alu_b      = TOLERANCE_NS;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        alu_op     = ALU_ADD;
        alu_b      = ACC_W'(delta);
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        alu_op = ALU_SUB;
        alu_b  = tsm;
        if (steps == '0) begin
          state_next = alu_neg ? ST_ACK : ST_SUB;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SUB: begin
        alu_op     = ALU_SUB;
        alu_b      = ACC_W'(cfg.timestep);
        state_next = at_cap ? ST_EMIT : ST_CHECK;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = last_flag ? ST_IDLE : ST_SUB;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      steps <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            steps <= '0;
            if (cannot_step) begin
              acc <= '0;
            end
          end
        end
        ST_ADD: acc <= alu_y;
        ST_SUB: begin
          steps <= steps_inc;
          acc   <= at_cap ? '0 : alu_y;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      delta <= in_delta;
      dyn   <= cfg.dyn_en && !in_p_dyn;
      col   <= in_p_col ? '0 : (cfg.world_mask & ~in_wmask);
    end
    if (state == ST_PREP) begin
      tsm <= alu_y;
    end
    if (state == ST_CHECK && steps != '0) begin
      last_flag <= alu_neg;
    end else if (state == ST_SUB && at_cap) begin
      last_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_ACK && out_free) begin
      out_valid <= 1'b1;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ACK && out_free) begin
      out_step <= 1'b0;
      out_dyn  <= 1'b0;
      out_col  <= '0;
      out_last <= 1'b1;
    end else if (state == ST_EMIT && out_free) begin
      out_step <= 1'b1;
      out_dyn  <= dyn;
      out_col  <= col;
      out_last <= last_flag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_TDATA_W - MASK_W - 1)'(0), out_col, out_dyn};
  assign m_tuser  = out_step;
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("acknowledge without last");

  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("acknowledge carries payload");

  a_steps_cap: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (steps <= cfg.cap))
    else $error("step count beyond cap");

  a_acc_floor: assert property (@(posedge clk) disable iff (rst)
    $signed(acc) >= ACC_FLOOR)
    else $error("accumulator below tolerance floor");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !out_free) |=> (state == ST_EMIT))
    else $error("step dropped while output stalled");
`endif

endmodule

// ===== src/fts_alu.sv =====
// Shared add/subtract unit for accumulator and timestep arithmetic.
module fts_alu (
  input  fts_pkg::alu_op_t           op,
  input  logic [fts_pkg::ACC_W-1:0]  a,
  input  logic [fts_pkg::ACC_W-1:0]  b,
  output logic [fts_pkg::ACC_W-1:0]  y,
  output logic                       neg
);
  import fts_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a + b;
    endcase
  end

  assign neg = y[ACC_W-1];

endmodule

// ===== src/fts_cfg.sv =====
// Configuration register file with derived cap and world mask.
module fts_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fts_pkg::CFG_DATA_W-1:0] cfg_data,
  output fts_pkg::cfg_t                  cfg
);
  import fts_pkg::*;

  logic [TS_W-1:0]     timestep;
  logic [STEPS_W-1:0]  max_steps;
  logic [WORLDS_W-1:0] active_worlds;
  logic                dyn_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timestep      <= TIMESTEP_RST;
      max_steps     <= MAX_STEPS_RST;
      active_worlds <= WORLDS_RST;
      dyn_en        <= DYN_EN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIMESTEP:      timestep      <= cfg_data[TS_W-1:0];
        REG_MAX_STEPS:     max_steps     <= cfg_data[STEPS_W-1:0];
        REG_ACTIVE_WORLDS: active_worlds <= cfg_data[WORLDS_W-1:0];
        REG_DYN_EN:        dyn_en        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.timestep   = timestep;
  assign cfg.cap        = eff_cap(max_steps);
  assign cfg.world_mask = world_mask(active_worlds);
  assign cfg.dyn_en     = dyn_en;

endmodule
